### rtl/cdrr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdrr_pkg
// Types, register codes and constants shared by the circle, disc and ring
// rasterizer.
// ----------------------------------------------------------------------------
package cdrr_pkg;

	// apb register file
	localparam int APB_AW = 5;
	localparam int APB_DW = 32;

	localparam logic [2:0] REG_CAMERA_X      = 3'd0;
	localparam logic [2:0] REG_CAMERA_Y      = 3'd1;
	localparam logic [2:0] REG_ZOOM          = 3'd2;
	localparam logic [2:0] REG_CANVAS_WIDTH  = 3'd3;
	localparam logic [2:0] REG_CANVAS_HEIGHT = 3'd4;

	localparam logic [15:0] ZOOM_RST   = 16'd256;
	localparam logic [12:0] WIDTH_RST  = 13'd640;
	localparam logic [12:0] HEIGHT_RST = 13'd480;

	// datapath widths
	localparam int MASK_W       = 63;
	localparam int RAD_W        = 5;
	localparam int ROW_W        = 6;
	localparam int SQ_W         = 10;
	localparam int DIST_W       = 11;
	localparam int BOUND_W      = 13;
	localparam int MUL_W        = 25;
	localparam int PROD_W       = 2 * MUL_W;
	localparam int PJ_W         = 52;
	localparam int CENTER_LIMIT = 4194304;

	typedef struct packed {
		logic               func;
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic [15:0]        shape_scale;
		logic [31:0]        shape_color;
	} in_item_t;

	typedef struct packed {
		logic signed [23:0] row_y;
		logic signed [23:0] left_x;
		logic [MASK_W-1:0]  row_mask;
		logic [31:0]        paint_color;
		logic               last;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MSC,
		ST_RAD,
		ST_CX,
		ST_CY,
		ST_SQ,
		ST_CLIP,
		ST_ROW
	} seq_state_t;

	// square of a pixel offset, a small constant table
	function automatic logic [SQ_W-1:0] sq5(input logic [RAD_W-1:0] v);
		logic [SQ_W-1:0] w;
		w = SQ_W'(v);
		return w * w;
	endfunction

endpackage

### rtl/circle_disc_ring_rasterizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_disc_ring_rasterizer
// Projects one disc or ring shape to screen space and emits one clipped span
// per scan row, top to bottom.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+---------------------------
//   in       | input     | in_valid / in_stall | in_data  (in_item_t)
//   out      | output    | out_valid/out_stall | out_data (out_item_t)
//   apb      | input     | psel/penable/pready | paddr, pwdata, prdata
//
// one shape: accept in idle, then setup in msc, rad, cx, cy and sq (five
// products on the shared multiplier: scale, x offset, y offset, outer and
// inner radius squares) and clip (bound rounding and column setup), then
// one row per cycle while the output does not stall, 2r+1 rows
// the input stalls from accept until the last row is in the output register
// output stalls hold the row register and freeze the row sequencer
// arst_n resets the sequencer, output valid and the apb registers
//
module circle_disc_ring_rasterizer #(
	parameter int MAX_RADIUS = 31,
	parameter int FRAC_BITS  = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [cdrr_pkg::APB_AW-1:0]    paddr,
	input  logic [cdrr_pkg::APB_DW-1:0]    pwdata,
	output logic [cdrr_pkg::APB_DW-1:0]    prdata,
	output logic                           pready,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  cdrr_pkg::in_item_t             in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output cdrr_pkg::out_item_t            out_data
);
	import cdrr_pkg::*;

	// scaled radius in Q.F, clamped to 64.0
	localparam int SW = FRAC_BITS + 7;
	localparam int TW = 34;
	localparam logic [TW-1:0] S_MAX  = TW'(64) << FRAC_BITS;
	localparam logic [SW-1:0] ONE    = SW'(1) << FRAC_BITS;
	localparam logic [SW-1:0] HALF   = ONE >> 1;
	localparam logic [PROD_W-1:0] RND = (PROD_W'(1) << (2 * FRAC_BITS)) - PROD_W'(1);

	// ------------------------------------------------------------------
	// apb register file
	// ------------------------------------------------------------------
	logic signed [23:0] cam_x_q, cam_y_q;
	logic [15:0]        zoom_q;
	logic [12:0]        width_q, height_q;
	logic               cfg_wr;
	logic [2:0]         cfg_idx;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[APB_AW-1:2];
	assign cfg_wr  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x_q  <= '0;
			cam_y_q  <= '0;
			zoom_q   <= ZOOM_RST;
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_CAMERA_X:      cam_x_q  <= pwdata[23:0];
				REG_CAMERA_Y:      cam_y_q  <= pwdata[23:0];
				REG_ZOOM:          zoom_q   <= pwdata[15:0];
				REG_CANVAS_WIDTH:  width_q  <= pwdata[12:0];
				REG_CANVAS_HEIGHT: height_q <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_CAMERA_X:      prdata = APB_DW'(unsigned'(cam_x_q));
			REG_CAMERA_Y:      prdata = APB_DW'(unsigned'(cam_y_q));
			REG_ZOOM:          prdata = APB_DW'(zoom_q);
			REG_CANVAS_WIDTH:  prdata = APB_DW'(width_q);
			REG_CANVAS_HEIGHT: prdata = APB_DW'(height_q);
			default:           prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// shape registers
	// ------------------------------------------------------------------
	seq_state_t         state_q, state_d;
	logic               func_q;
	logic signed [23:0] cx_q, cy_q;
	logic [15:0]        scale_q;
	logic [31:0]        color_q;
	logic [SW-1:0]      s_q, lob_q;
	logic [RAD_W-1:0]   r_q;
	logic signed [23:0] scx_q, scy_q, left_q, py_q;
	logic [BOUND_W-1:0] hi_q, lo_q;
	logic [ROW_W-1:0]   row_q;
	logic [SQ_W-1:0]    xsq_q [MASK_W];
	logic [MASK_W-1:0]  colok_q;

	// output register
	out_item_t          out_q;
	logic               out_valid_q;
	logic               out_load;

	// ------------------------------------------------------------------
	// shared multiplier, product registered for the next step
	// ------------------------------------------------------------------
	logic signed [MUL_W-1:0]  mul_a, mul_b, dx_w, dy_w, zoom_w;
	logic signed [PROD_W-1:0] mul_p, prod_q;

	assign dx_w   = MUL_W'(cx_q) - MUL_W'(cam_x_q);
	assign dy_w   = MUL_W'(cy_q) - MUL_W'(cam_y_q);
	assign zoom_w = $signed(MUL_W'(zoom_q));
	assign mul_p  = mul_a * mul_b;

	always_ff @(posedge clk) begin
		prod_q <= mul_p;
	end

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	logic row_last;

	assign row_last = (row_q == {r_q, 1'b0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		mul_a    = '0;
		mul_b    = '0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = ST_MSC;
				end
			end
			ST_MSC: begin
				mul_a   = $signed(MUL_W'(scale_q));
				mul_b   = zoom_w;
				state_d = ST_RAD;
			end
			ST_RAD: begin
				mul_a   = dx_w;
				mul_b   = zoom_w;
				state_d = ST_CX;
			end
			ST_CX: begin
				mul_a   = dy_w;
				mul_b   = zoom_w;
				state_d = ST_CY;
			end
			ST_CY: begin
				mul_a   = $signed(MUL_W'(s_q));
				mul_b   = $signed(MUL_W'(s_q));
				state_d = ST_SQ;
			end
			ST_SQ: begin
				mul_a   = $signed(MUL_W'(lob_q));
				mul_b   = $signed(MUL_W'(lob_q));
				state_d = ST_CLIP;
			end
			ST_CLIP: begin
				state_d = ST_ROW;
			end
			ST_ROW: begin
				out_load = !out_valid_q || !out_stall;
				if (out_load && row_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// radius: scale * zoom, tripled for a ring, clamped and rounded
	// ------------------------------------------------------------------
	logic [TW-1:0] t_base, t_sum, t_sh;
	logic [SW-1:0] s_w, lob_w;
	logic [SW:0]   rs_w;
	logic [RAD_W-1:0] r_w;

	assign t_base = prod_q[TW-1:0];
	assign t_sum  = t_base + (func_q ? {t_base[TW-2:0], 1'b0} : '0);
	assign t_sh   = t_sum >> FRAC_BITS;
	assign s_w    = (t_sh > S_MAX) ? S_MAX[SW-1:0] : t_sh[SW-1:0];

	assign rs_w   = ({1'b0, s_q} + {1'b0, HALF}) >> FRAC_BITS;
	assign r_w    = (rs_w > (SW + 1)'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : rs_w[RAD_W-1:0];
	assign lob_w  = (s_q >= ONE) ? (s_q - ONE) : (ONE - s_q);

	// ------------------------------------------------------------------
	// center projection: floor(d * zoom / 2^2F + extent/2), clamped
	// ------------------------------------------------------------------
	logic [12:0]              ext_sel;
	logic signed [PJ_W-1:0]   ext_term, proj_sum, proj_fl;
	logic signed [23:0]       proj_c;

	assign ext_sel  = (state_q == ST_CX) ? width_q : height_q;
	assign ext_term = $signed(PJ_W'(ext_sel) << (2 * FRAC_BITS - 1));
	assign proj_sum = PJ_W'(prod_q) + ext_term;
	assign proj_fl  = proj_sum >>> (2 * FRAC_BITS);

	always_comb begin
		if (proj_fl > PJ_W'(CENTER_LIMIT)) begin
			proj_c = 24'(CENTER_LIMIT);
		end else if (proj_fl < -PJ_W'(CENTER_LIMIT)) begin
			proj_c = -24'(CENTER_LIMIT);
		end else begin
			proj_c = proj_fl[23:0];
		end
	end

	// squared bounds brought back to whole pixels: floor for the outer,
	// ceiling for the inner
	logic [PROD_W-1:0] hi_sh, lo_sh;

	assign hi_sh = unsigned'(prod_q) >> (2 * FRAC_BITS);
	assign lo_sh = (unsigned'(prod_q) + RND) >> (2 * FRAC_BITS);

	// ------------------------------------------------------------------
	// per-column setup: offset squares and canvas window
	// ------------------------------------------------------------------
	logic [SQ_W-1:0]    xsq_w [MASK_W];
	logic [MASK_W-1:0]  colok_w;
	logic signed [24:0] pk_w [MASK_W];

	always_comb begin
		for (int k = 0; k < MASK_W; k++) begin
			xsq_w[k] = sq5((ROW_W'(k) >= ROW_W'(r_q)) ? RAD_W'(ROW_W'(k) - ROW_W'(r_q))
			                                          : RAD_W'(ROW_W'(r_q) - ROW_W'(k)));
			pk_w[k]  = 25'(left_q) + 25'(k);
			colok_w[k] = (pk_w[k] >= 0) && (pk_w[k] < $signed(25'(width_q)))
			             && (ROW_W'(k) <= {r_q, 1'b0});
		end
	end

	// ------------------------------------------------------------------
	// row mask
	// ------------------------------------------------------------------
	logic [RAD_W-1:0]   ay_w;
	logic [SQ_W-1:0]    ysq_w;
	logic               row_ok;
	logic [DIST_W-1:0]  dist_w [MASK_W];
	logic [MASK_W-1:0]  mask_w;

	assign ay_w   = (row_q >= ROW_W'(r_q)) ? RAD_W'(row_q - ROW_W'(r_q))
	                                       : RAD_W'(ROW_W'(r_q) - row_q);
	assign ysq_w  = sq5(ay_w);
	assign row_ok = (py_q >= 0) && (py_q < $signed(24'(height_q)));

	always_comb begin
		for (int k = 0; k < MASK_W; k++) begin
			dist_w[k] = DIST_W'(xsq_q[k]) + DIST_W'(ysq_w);
			mask_w[k] = row_ok && colok_q[k]
			            && (BOUND_W'(dist_w[k]) <= hi_q)
			            && (!func_q || (BOUND_W'(dist_w[k]) >= lo_q));
		end
	end

	// ------------------------------------------------------------------
	// datapath registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					func_q  <= in_data.func;
					cx_q    <= in_data.pos_x;
					cy_q    <= in_data.pos_y;
					scale_q <= in_data.shape_scale;
					color_q <= in_data.shape_color;
				end
			end
			ST_RAD: begin
				s_q <= s_w;
			end
			ST_CX: begin
				scx_q <= proj_c;
				r_q   <= r_w;
				lob_q <= lob_w;
			end
			ST_CY: begin
				scy_q <= proj_c;
			end
			ST_SQ: begin
				hi_q   <= hi_sh[BOUND_W-1:0];
				left_q <= scx_q - 24'(r_q);
			end
			ST_CLIP: begin
				lo_q    <= lo_sh[BOUND_W-1:0];
				py_q    <= scy_q - 24'(r_q);
				row_q   <= '0;
				colok_q <= colok_w;
				for (int k = 0; k < MASK_W; k++) begin
					xsq_q[k] <= xsq_w[k];
				end
			end
			ST_ROW: begin
				if (out_load) begin
					row_q <= row_q + ROW_W'(1);
					py_q  <= py_q + 24'sd1;
				end
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.row_y       <= py_q;
			out_q.left_x      <= left_q;
			out_q.row_mask    <= mask_w;
			out_q.paint_color <= color_q;
			out_q.last        <= row_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	// an accepted shape always starts the multiply sequence
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == ST_MSC)
		else $error("accepted shape did not start the sequence");

	// the row counter never runs past the last row of the shape
	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROW |-> row_q <= {r_q, 1'b0})
		else $error("row counter beyond shape height");

	// a stalled row holds its payload until it is taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled row changed before transfer");

	// a non-final row transfer is followed at once by the next row
	a_rows_continue: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_data.last
		|=> out_valid && (state_q == ST_ROW || out_data.last))
		else $error("row sequence broken after a transfer");
`endif

endmodule
